// File: src/cdo_pkg.sv
// Shared types, constants and calendar functions for the date offset core.
`default_nettype none

package cdo_pkg;

   // Widths of the stored year and of the day count.
   localparam int YEAR_WIDTH  = 16;
   localparam int COUNT_WIDTH = 16;

   // Working day value must hold the day plus a full day count.
   localparam int DAY_WIDTH = COUNT_WIDTH + 1;

   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX  = '1;
   localparam logic [YEAR_WIDTH-1:0] YEAR_ZERO = '0;
   localparam logic [YEAR_WIDTH-1:0] YEAR_ONE  = YEAR_WIDTH'(1);

   localparam logic [3:0] MONTH_NONE = 4'd0;
   localparam logic [3:0] MONTH_JAN  = 4'd1;
   localparam logic [3:0] MONTH_FEB  = 4'd2;
   localparam logic [3:0] MONTH_DEC  = 4'd12;
   localparam logic [3:0] MONTH_ONE  = 4'd1;

   localparam logic [4:0] DAY_NONE = 5'd0;

   // Multiplicative inverse of an odd number modulo 2^YEAR_WIDTH.
   // Newton steps double the number of correct low bits each time.
   function automatic logic [YEAR_WIDTH-1:0] inv_odd(input logic [63:0] d);
      logic [63:0] x;
      x = d;
      for (int i = 0; i < 5; i++) begin
         x = x * (64'd2 - d * x);
      end
      return x[YEAR_WIDTH-1:0];
   endfunction

   // A year is a multiple of 25 exactly when year * inv(25) stays at or
   // below the largest year divided by 25.
   localparam logic [YEAR_WIDTH-1:0] INV25       = inv_odd(64'd25);
   localparam logic [YEAR_WIDTH-1:0] DIV25_LIMIT = YEAR_WIDTH'(YEAR_MAX / 25);

   typedef enum logic [1:0] {
      OP_SET = 2'd0,
      OP_ADD = 2'd1,
      OP_SUB = 2'd2,
      OP_NOP = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAP,
      ST_SET,
      ST_ADD,
      ST_SUB,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                  operation;
      logic [YEAR_WIDTH-1:0]   new_year;
      logic [3:0]              new_month;
      logic [4:0]              new_day;
      logic [COUNT_WIDTH-1:0]  day_count;
   } req_type;

   typedef struct packed {
      logic [YEAR_WIDTH-1:0] cur_year;
      logic [3:0]            cur_month;
      logic [4:0]            cur_day;
      logic                  range_error;
   } rsp_type;

   // Length of a month; month zero and codes above December have length 0.
   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// File: src/calendar_date_day_offset_core.sv
// Top level of the Gregorian date register with day-count add and subtract.
//
// Usage: a request on req_valid/req_ready carries an operation code with a
// new date (set) or a day count (add, subtract). Each request produces one
// response on rsp_valid/rsp_ready holding the stored date after the
// operation and a range error flag. On a range error the date is kept.
// The block takes one request at a time: req_ready is high only while the
// sequencer is idle.
// A set passes the leap and set states, a no-op goes straight to the
// final state. An add or a subtract walks one month per step and goes
// back to the leap state at each year boundary, since the shared multiply
// unit recomputes the leap flag whenever the working year changes. The
// worst case, a count of 65535 days, is about 2150 months.
// Reset sets the date to year 0, January 1 and empties the response
// register. A stalled response stays in its register; the finished
// request waits in its last state until the register frees, and a new
// request may be taken while an earlier response is still pending.
`default_nettype none

module calendar_date_day_offset_core
   import cdo_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [YEAR_WIDTH-1:0]  work_year_ff, work_year_in;
   logic [3:0]             work_month_ff, work_month_in;
   logic [DAY_WIDTH-1:0]   work_day_ff, work_day_in;
   logic                   leap_ff, leap_in;
   logic                   err_ff, err_in;
   logic [YEAR_WIDTH-1:0]  year_reg_ff, year_reg_in;
   logic [3:0]             month_reg_ff, month_reg_in;
   logic [4:0]             day_reg_ff, day_reg_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   leap_calc;
   logic [4:0]             cur_len;
   logic [4:0]             prev_len;
   logic [DAY_WIDTH-1:0]   cur_len_ext;
   logic [DAY_WIDTH-1:0]   count_ext;
   logic                   add_more;
   logic                   sub_more;
   logic                   rsp_free;

   // Shared leap unit always looks at the working year.
   cdo_leap_calc u_leap (
      .year (work_year_ff),
      .leap (leap_calc)
   );

   // Month lengths for the current and the preceding month.
   assign cur_len     = days_in(work_month_ff, leap_ff);
   assign prev_len    = days_in(work_month_ff - MONTH_ONE, leap_ff);
   assign cur_len_ext = DAY_WIDTH'(cur_len);
   assign count_ext   = DAY_WIDTH'(count_ff);
   assign add_more    = (work_day_ff > cur_len_ext);
   assign sub_more    = (work_day_ff <= count_ext);
   assign rsp_free    = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.operation == OP_NOP) ? ST_DONE : ST_LEAP;
            end
         end
         ST_LEAP: begin
            unique case (op_ff)
               OP_SET:  state_in = ST_SET;
               OP_ADD:  state_in = ST_ADD;
               OP_SUB:  state_in = ST_SUB;
               default: state_in = ST_DONE;
            endcase
         end
         ST_SET: begin
            state_in = ST_DONE;
         end
         ST_ADD: begin
            if (!add_more) begin
               state_in = ST_DONE;
            end else if (work_month_ff == MONTH_DEC) begin
               state_in = (work_year_ff == YEAR_MAX) ? ST_DONE : ST_LEAP;
            end
         end
         ST_SUB: begin
            if (!sub_more) begin
               state_in = ST_DONE;
            end else if (work_month_ff <= MONTH_JAN) begin
               state_in = (work_year_ff == YEAR_ZERO) ? ST_DONE : ST_LEAP;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs of each state.
   always_comb begin
      op_in         = op_ff;
      count_in      = count_ff;
      work_year_in  = work_year_ff;
      work_month_in = work_month_ff;
      work_day_in   = work_day_ff;
      leap_in       = leap_ff;
      err_in        = err_ff;
      year_reg_in   = year_reg_ff;
      month_reg_in  = month_reg_ff;
      day_reg_in    = day_reg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.operation;
               count_in = req_data.day_count;
               err_in   = 1'b0;
               case (req_data.operation)
                  OP_SET: begin
                     work_year_in  = req_data.new_year;
                     work_month_in = (req_data.new_month > MONTH_DEC) ? MONTH_NONE
                                                                      : req_data.new_month;
                     work_day_in   = DAY_WIDTH'(req_data.new_day);
                  end
                  OP_ADD: begin
                     work_year_in  = year_reg_ff;
                     work_month_in = month_reg_ff;
                     work_day_in   = DAY_WIDTH'(day_reg_ff) + DAY_WIDTH'(req_data.day_count);
                  end
                  OP_SUB: begin
                     work_year_in  = year_reg_ff;
                     work_month_in = month_reg_ff;
                     work_day_in   = DAY_WIDTH'(day_reg_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEAP: begin
            leap_in = leap_calc;
         end
         ST_SET: begin
            // A day past the month's end is cleared.
            year_reg_in  = work_year_ff;
            month_reg_in = work_month_ff;
            day_reg_in   = add_more ? DAY_NONE : work_day_ff[4:0];
         end
         ST_ADD: begin
            // Use up one month, rolling December into the next year.
            if (add_more) begin
               if (work_month_ff == MONTH_DEC) begin
                  if (work_year_ff == YEAR_MAX) begin
                     err_in = 1'b1;
                  end else begin
                     work_day_in   = work_day_ff - cur_len_ext;
                     work_month_in = MONTH_JAN;
                     work_year_in  = work_year_ff + YEAR_ONE;
                  end
               end else begin
                  work_day_in   = work_day_ff - cur_len_ext;
                  work_month_in = work_month_ff + MONTH_ONE;
               end
            end else begin
               year_reg_in  = work_year_ff;
               month_reg_in = work_month_ff;
               day_reg_in   = work_day_ff[4:0];
            end
         end
         ST_SUB: begin
            // Borrow the previous month's length until the count fits.
            if (sub_more) begin
               if (work_month_ff <= MONTH_JAN) begin
                  if (work_year_ff == YEAR_ZERO) begin
                     err_in = 1'b1;
                  end else begin
                     work_year_in  = work_year_ff - YEAR_ONE;
                     work_month_in = MONTH_DEC;
                     work_day_in   = work_day_ff + DAY_WIDTH'(days_in(MONTH_DEC, 1'b0));
                  end
               end else begin
                  work_month_in = work_month_ff - MONTH_ONE;
                  work_day_in   = work_day_ff + DAY_WIDTH'(prev_len);
               end
            end else begin
               year_reg_in  = work_year_ff;
               month_reg_in = work_month_ff;
               day_reg_in   = 5'(work_day_ff - count_ext);
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.cur_year    = year_reg_ff;
               rsp_data_in.cur_month   = month_reg_ff;
               rsp_data_in.cur_day     = day_reg_ff;
               rsp_data_in.range_error = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and the stored date.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         year_reg_ff  <= YEAR_ZERO;
         month_reg_ff <= MONTH_JAN;
         day_reg_ff   <= 5'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         year_reg_ff  <= year_reg_in;
         month_reg_ff <= month_reg_in;
         day_reg_ff   <= day_reg_in;
      end
   end

   // Working registers and the response payload.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      count_ff      <= count_in;
      work_year_ff  <= work_year_in;
      work_month_ff <= work_month_in;
      work_day_ff   <= work_day_in;
      leap_ff       <= leap_in;
      err_ff        <= err_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // The stored date never moves while the sequencer is idle.
   a_idle_date_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> ($stable(year_reg_ff) && $stable(month_reg_ff)
                                 && $stable(day_reg_ff)))
      else $error("stored date changed while idle");

   // The stored month is always a real month or zero.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      month_reg_ff <= MONTH_DEC)
      else $error("stored month out of range");

   // A new response only comes out of the final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) || $past(rsp_ready)) && rsp_valid_ff
         |-> ($past(state_ff) == ST_DONE))
      else $error("response issued outside the final state");

endmodule

`default_nettype wire

// File: src/cdo_leap_calc.sv
// Gregorian leap year test built on one multiply and compare.
`default_nettype none

module cdo_leap_calc
   import cdo_pkg::*;
(
   input  wire logic [YEAR_WIDTH-1:0] year,
   output logic                       leap
);

   logic [YEAR_WIDTH-1:0] prod;
   logic                  div4;
   logic                  div25;
   logic                  div100;
   logic                  div400;

   // Divisibility by 25 through the modular inverse.
   assign prod  = year * INV25;
   assign div25 = (prod <= DIV25_LIMIT);

   // 100 = 4 * 25 and 400 = 16 * 25.
   assign div4   = (year[1:0] == 2'b00);
   assign div100 = div4 && div25;
   assign div400 = div100 && (year[3:0] == 4'b0000);

   assign leap = (div4 && !div100) || div400;

endmodule

`default_nettype wire
